>>> rtl/gmcp_pkg.sv
// Shared constants, register codes and neighbor step tables for the grid path core.
package gmcp_pkg;

  localparam int COST_W = 28;
  localparam logic [COST_W-1:0] COST_MAX = 28'hFFFFFFF;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 3'd0,
    CFG_COL_COUNT = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_GOAL_ROW  = 3'd4,
    CFG_GOAL_COL  = 3'd5
  } cfg_reg_t;

  // Row step of neighbor d: -1, 0 or +1.
  function automatic logic signed [1:0] step_dr(input logic [2:0] d);
    logic signed [1:0] s;
    unique case (d)
      3'd0, 3'd1:             s = 2'sd0;
      3'd2, 3'd4, 3'd5:       s = -2'sd1;
      default:                s = 2'sd1;
    endcase
    return s;
  endfunction

  // Column step of neighbor d: -1, 0 or +1.
  function automatic logic signed [1:0] step_dc(input logic [2:0] d);
    logic signed [1:0] s;
    unique case (d)
      3'd2, 3'd3:             s = 2'sd0;
      3'd0, 3'd5, 3'd7:       s = -2'sd1;
      default:                s = 2'sd1;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/grid_min_cost_path_core.sv
// Grid loader and iterative relaxation search for the minimum-cost 8-neighbor path.
//
//  channel   ports                                   transfer
//  input     start, busy, in_cell_value, in_last_cell start & !busy at a rising edge
//  result    out_valid, out_path_cost                one cycle with out_valid high
//  config    cfg_we, cfg_index, cfg_wdata            cfg_we high at a rising edge
//
// Cells load at one per cycle into the grid memory. The cell marked last starts the
// search: a clear pass over the cost memory, then repeated forward sweeps; each cell
// reads itself, then each neighbor inside the grid in turn, paced by the single read
// port of each memory and the shared multiply/add/compare unit. Sweeps repeat until
// one changes nothing, then the goal cost is read. busy stays high throughout. A start
// or goal outside the grid gives COST_MAX with no search. Reset is synchronous, active
// low; the receiver cannot stall, so results are never held.
module grid_min_cost_path_core
  import gmcp_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           in_cell_value,
  input  logic                 in_last_cell,
  output logic                 out_valid,
  output logic [COST_W-1:0]    out_path_cost,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
  localparam int IDX_W    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int CW       = $clog2(MAX_COLS + 1);
  localparam int MW       = RW + CW + 1;
  localparam int PROD_W   = 2 * VALUE_BITS;
  localparam int SUM_W    = ((PROD_W > COST_W) ? PROD_W : COST_W) + 1;
  localparam int NA_W     = IDX_W + 2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_SETS  = 11'b00000000100,
    S_HREAD = 11'b00000001000,
    S_HCAP  = 11'b00000010000,
    S_NREAD = 11'b00000100000,
    S_NMUL  = 11'b00001000000,
    S_NACC  = 11'b00010000000,
    S_WB    = 11'b00100000000,
    S_GREAD = 11'b01000000000,
    S_GWAIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] row_count_r, col_count_r;
  logic [5:0] start_row_r, start_col_r, goal_row_r, goal_col_r;

  logic [IDX_W:0]   load_idx_r;
  logic [IDX_W:0]   total_r;
  logic [IDX_W-1:0] here_r;
  logic [RW-1:0]    r_r;
  logic [CW-1:0]    c_r;
  logic [2:0]       d_r;
  logic             changed_r, moved_r;
  logic             out_valid_r;
  logic [COST_W-1:0] out_cost_r;

  logic [VALUE_BITS-1:0] vh_r;
  logic [COST_W-1:0]     best_r, ncost_r;
  logic [PROD_W-1:0]     prod_r;

  logic [VALUE_BITS-1:0] grid_mem [CELL_CAP];
  logic [VALUE_BITS-1:0] grd_r;
  logic [COST_W-1:0]     cost_mem [CELL_CAP];
  logic [COST_W-1:0]     crd_r;

  logic                  accept;
  logic [RW-1:0]         rows_eff;
  logic [CW-1:0]         cols_eff;
  logic                  range_bad;
  logic [MW-1:0]         row_sel, col_sel, lin;
  logic signed [1:0]     dr, dc;
  logic                  nvalid;
  logic signed [NA_W-1:0] roff, naddr_s;
  logic [IDX_W-1:0]      naddr;
  logic                  last_here, last_col;
  logic [31:0]           cell_ext;
  logic                  gwe;
  logic [IDX_W-1:0]      gra;
  logic                  cwe;
  logic [IDX_W-1:0]      cwa, cra;
  logic [COST_W-1:0]     cwd;
  logic [SUM_W-1:0]      sum;
  logic [COST_W-1:0]     cand;

  assign accept        = start && (state_r == S_IDLE);
  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_path_cost = out_cost_r;

  // Clamp the grid size to the storage limits.
  always_comb begin
    if (row_count_r == 7'd0) begin
      rows_eff = RW'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count_r);
    end
    if (col_count_r == 7'd0) begin
      cols_eff = CW'(1);
    end else if (32'(col_count_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(col_count_r);
    end
  end

  assign range_bad = (32'(start_row_r) >= 32'(rows_eff)) ||
                     (32'(start_col_r) >= 32'(cols_eff)) ||
                     (32'(goal_row_r) >= 32'(rows_eff)) ||
                     (32'(goal_col_r) >= 32'(cols_eff));

  // Share one index multiplier: grid size, start index or goal index.
  always_comb begin
    priority case (1'b1)
      (state_r == S_IDLE): begin
        row_sel = MW'(rows_eff);
        col_sel = '0;
      end
      (state_r == S_SETS): begin
        row_sel = MW'(start_row_r);
        col_sel = MW'(start_col_r);
      end
      default: begin
        row_sel = MW'(goal_row_r);
        col_sel = MW'(goal_col_r);
      end
    endcase
  end
  assign lin = row_sel * MW'(cols_eff) + col_sel;

  // Neighbor address and bounds for step d.
  assign dr = step_dr(d_r);
  assign dc = step_dc(d_r);
  always_comb begin
    nvalid = 1'b1;
    if (dr == -2'sd1 && r_r == '0) nvalid = 1'b0;
    if (dr == 2'sd1 && (32'(r_r) + 1) >= 32'(rows_eff)) nvalid = 1'b0;
    if (dc == -2'sd1 && c_r == '0) nvalid = 1'b0;
    if (dc == 2'sd1 && (32'(c_r) + 1) >= 32'(cols_eff)) nvalid = 1'b0;
    if (dr == -2'sd1) begin
      roff = -$signed(NA_W'(cols_eff));
    end else if (dr == 2'sd1) begin
      roff = $signed(NA_W'(cols_eff));
    end else begin
      roff = '0;
    end
  end
  assign naddr_s = $signed(NA_W'(here_r)) + roff + NA_W'(dc);
  assign naddr   = naddr_s[IDX_W-1:0];

  assign last_here = ((IDX_W + 1)'(here_r) + 1'b1) == total_r;
  assign last_col  = (32'(c_r) + 1) == 32'(cols_eff);

  // Grid memory: load writes, search reads.
  assign cell_ext = 32'(in_cell_value);
  assign gwe      = accept && (32'(load_idx_r) < CELL_CAP);
  assign gra      = (state_r == S_HREAD) ? here_r : naddr;
  always_ff @(posedge clk) begin
    if (gwe) grid_mem[load_idx_r[IDX_W-1:0]] <= cell_ext[VALUE_BITS-1:0];
    grd_r <= grid_mem[gra];
  end

  // Cost memory: clear pass, start seed, write-back; reads for here, neighbor, goal.
  always_comb begin
    cwe = 1'b0;
    cwa = here_r;
    cwd = best_r;
    unique case (state_r)
      S_CLEAR: begin
        cwe = 1'b1;
        cwd = COST_MAX;
      end
      S_SETS: begin
        cwe = 1'b1;
        cwa = lin[IDX_W-1:0];
        cwd = '0;
      end
      S_WB: cwe = 1'b1;
      default: ;
    endcase
    priority case (1'b1)
      (state_r == S_HREAD): cra = here_r;
      (state_r == S_GREAD): cra = lin[IDX_W-1:0];
      default:              cra = naddr;
    endcase
  end
  always_ff @(posedge clk) begin
    if (cwe) cost_mem[cwa] <= cwd;
    crd_r <= cost_mem[cra];
  end

  // Shared add and saturate for one candidate.
  assign sum  = SUM_W'(ncost_r) + SUM_W'(prod_r);
  assign cand = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_last_cell && !range_bad) state_nxt = S_CLEAR;
      S_CLEAR: if (last_here) state_nxt = S_SETS;
      S_SETS:  state_nxt = S_HREAD;
      S_HREAD: state_nxt = S_HCAP;
      S_HCAP:  state_nxt = S_NREAD;
      S_NREAD: begin
        if (nvalid) begin
          state_nxt = S_NMUL;
        end else if (d_r == 3'd7) begin
          state_nxt = S_WB;
        end
      end
      S_NMUL:  state_nxt = S_NACC;
      S_NACC:  state_nxt = (d_r == 3'd7) ? S_WB : S_NREAD;
      S_WB: begin
        if (!last_here) begin
          state_nxt = S_HREAD;
        end else if (changed_r || moved_r) begin
          state_nxt = S_HREAD;
        end else begin
          state_nxt = S_GREAD;
        end
      end
      S_GREAD: state_nxt = S_GWAIT;
      S_GWAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= 7'd1;
      col_count_r <= 7'd1;
      start_row_r <= '0;
      start_col_r <= '0;
      goal_row_r  <= '0;
      goal_col_r  <= '0;
      load_idx_r  <= '0;
      total_r     <= '0;
      here_r      <= '0;
      r_r         <= '0;
      c_r         <= '0;
      d_r         <= '0;
      changed_r   <= 1'b0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      // Take configuration writes; ignore indexes past the list.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          CFG_COL_COUNT: col_count_r <= cfg_wdata;
          CFG_START_ROW: start_row_r <= cfg_wdata[5:0];
          CFG_START_COL: start_col_r <= cfg_wdata[5:0];
          CFG_GOAL_ROW:  goal_row_r  <= cfg_wdata[5:0];
          CFG_GOAL_COL:  goal_col_r  <= cfg_wdata[5:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            // Latch the cell count for the clear pass and the sweeps.
            if (in_last_cell) begin
              load_idx_r <= '0;
              here_r     <= '0;
              total_r    <= lin[IDX_W:0];
              if (range_bad) out_valid_r <= 1'b1;
            end else if (gwe) begin
              load_idx_r <= load_idx_r + 1'b1;
            end
          end
        end
        S_CLEAR: begin
          here_r <= here_r + 1'b1;
        end
        S_SETS: begin
          here_r    <= '0;
          r_r       <= '0;
          c_r       <= '0;
          changed_r <= 1'b0;
        end
        S_HCAP: begin
          d_r     <= '0;
          moved_r <= 1'b0;
        end
        S_NREAD: begin
          if (!nvalid) d_r <= d_r + 1'b1;
        end
        S_NACC: begin
          d_r <= d_r + 1'b1;
          if (ncost_r < COST_MAX && cand < best_r) moved_r <= 1'b1;
        end
        S_WB: begin
          // Advance to the next cell, or wrap to the first cell at the end of a sweep.
          if (last_here) begin
            here_r    <= '0;
            r_r       <= '0;
            c_r       <= '0;
            changed_r <= 1'b0;
          end else begin
            here_r    <= here_r + 1'b1;
            changed_r <= changed_r | moved_r;
            if (last_col) begin
              c_r <= '0;
              r_r <= r_r + 1'b1;
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        S_GWAIT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && in_last_cell && range_bad) out_cost_r <= COST_MAX;
    if (state_r == S_GWAIT) out_cost_r <= crd_r;
    if (state_r == S_HCAP) begin
      vh_r   <= grd_r;
      best_r <= crd_r;
    end
    if (state_r == S_NMUL) begin
      ncost_r <= crd_r;
      prod_r  <= (vh_r == grd_r) ? '0 : PROD_W'(vh_r) * PROD_W'(grd_r);
    end
    if (state_r == S_NACC && ncost_r < COST_MAX && cand < best_r) best_r <= cand;
  end

endmodule

>>> rtl/gmcp_checker.sv
// Port-level checker for the grid path core, bound to the top level.
module gmcp_checker
  import gmcp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_last_cell,
  input logic              out_valid,
  input logic [COST_W-1:0] out_path_cost
);

  // A result never shows while a search still runs.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result shown while busy");

  // A cell that is not the last one causes no result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_cell) |=> !out_valid)
    else $error("result after a non-final cell");

  // A result follows a search or a final cell transfer.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && in_last_cell)))
    else $error("result without a cause");

  // The end of a search always delivers its result.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> out_valid)
    else $error("search ended without result");

  // The saturated cost stays within its range.
  a_cost_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_path_cost <= COST_MAX))
    else $error("cost out of range");

endmodule

bind grid_min_cost_path_core gmcp_checker u_gmcp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last_cell (in_last_cell),
  .out_valid    (out_valid),
  .out_path_cost(out_path_cost)
);
